>>> sv/wbps_pkg.sv
package wbps_pkg;

	// Fixed geometry of the pattern registers and the result address.
	localparam int unsigned PAT_BYTES  = 16;
	localparam int unsigned LEN_W      = 5;
	localparam int unsigned KIDX_W     = 4;
	localparam int unsigned OUT_ADDR_W = 48;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 64;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WILDCARD_MASK  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ADDR_ORIGIN    = 3'd4;

	typedef logic [PAT_BYTES-1:0][7:0] pat_bytes_t;
	typedef logic [PAT_BYTES-1:0]      wild_mask_t;
	typedef logic [LEN_W-1:0]          pat_len_t;
	typedef logic [OUT_ADDR_W-1:0]     out_addr_t;

endpackage

>>> sv/wbps_if.sv
interface wbps_byte_if
	import wbps_pkg::*;
();
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wbps_result_if
	import wbps_pkg::*;
();
	logic      valid;
	logic      ready;
	logic      match_found;
	out_addr_t match_address;

	modport source (output valid, output match_found, output match_address, input ready);
	modport sink (input valid, input match_found, input match_address, output ready);
endinterface

interface wbps_cfg_if
	import wbps_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> sv/wbps_cell.sv
module wbps_cell
	import wbps_pkg::*;
#(
	parameter int unsigned INDEX = 0
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       shift_en,
	input  logic       clear,
	input  logic [7:0] din,
	input  pat_len_t   pat_len,
	input  pat_bytes_t pat_bytes,
	input  wild_mask_t wild_mask,
	output logic [7:0] hist_q,
	output logic       ok
);

	localparam pat_len_t IDX = LEN_W'(INDEX);

	logic              active;
	pat_len_t          k_full;
	logic [KIDX_W-1:0] k;

	// This cell holds the byte that is INDEX positions older than the newest,
	// so it lines up with pattern byte (length - 1 - INDEX).
	assign active = IDX < pat_len;
	assign k_full = pat_len - IDX - LEN_W'(1);
	assign k      = k_full[KIDX_W-1:0];
	assign ok     = !active || wild_mask[k] || (din == pat_bytes[k]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else if (clear) begin
			hist_q <= '0;
		end else if (shift_en) begin
			hist_q <= din;
		end
	end

endmodule

>>> sv/wbps_result.sv
module wbps_result
	import wbps_pkg::*;
#(
	parameter int unsigned ADDRESS_WIDTH = 48
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  logic                     found,
	input  logic [ADDRESS_WIDTH-1:0] offset,
	input  out_addr_t                addr_origin,
	output logic                     push_ready,
	wbps_result_if.source            result_out
);

	logic                     valid_s1;
	logic                     found_s1;
	logic [ADDRESS_WIDTH-1:0] offset_s1;
	logic                     valid_s2;
	logic                     found_s2;
	out_addr_t                addr_s2;
	logic                     s2_ready;
	logic [ADDRESS_WIDTH-1:0] sum;

	assign s2_ready   = !valid_s2 || result_out.ready;
	assign push_ready = !valid_s1 || s2_ready;

	// The sum wraps at the scan address width before it is cut to the port width.
	assign sum = ADDRESS_WIDTH'(addr_origin) + offset_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (push_ready) begin
				valid_s1 <= push;
			end
			if (s2_ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_ready && push) begin
			found_s1  <= found;
			offset_s1 <= offset;
		end
		if (s2_ready && valid_s1) begin
			found_s2 <= found_s1;
			addr_s2  <= found_s1 ? OUT_ADDR_W'(sum) : '0;
		end
	end

	assign result_out.valid         = valid_s2;
	assign result_out.match_found   = found_s2;
	assign result_out.match_address = addr_s2;

endmodule

>>> sv/wildcard_byte_pattern_scan_core.sv
// Channel     Dir  Payload
// byte_in     in   data_byte[7:0], last_byte
// result_out  out  match_found, match_address[47:0]
// cfg         in   index[2:0], data[63:0] (always ready)
//
// One byte is taken per cycle while the input is not stalled; the compare of
// every history cell against its pattern byte is done in parallel, in the
// cycle the byte arrives. A result passes the match stage, then the address
// add into the output register, before it leaves.
// Reset clears the history, the byte count and the output stages; the
// pattern registers reset to length one and all other fields zero.
// While the output is stalled the first result stage still takes one more
// result; once both stages are full, every byte waits until the output moves.
module wildcard_byte_pattern_scan_core
	import wbps_pkg::*;
#(
	parameter int unsigned PATTERN_MAX   = 16,
	parameter int unsigned ADDRESS_WIDTH = 48
) (
	input  logic          clk,
	input  logic          arst_n,
	wbps_byte_if.sink     byte_in,
	wbps_result_if.source result_out,
	wbps_cfg_if.sink      cfg
);

	localparam int unsigned NCELL = (PATTERN_MAX < PAT_BYTES) ? PATTERN_MAX : PAT_BYTES;
	localparam pat_len_t    NCELL_LEN = LEN_W'(NCELL);

	pat_len_t                 pattern_length_q;
	pat_bytes_t               pattern_q;
	wild_mask_t               wildcard_q;
	out_addr_t                addr_origin_q;
	logic [ADDRESS_WIDTH-1:0] count_q;
	logic                     scan_done_q;

	logic                     in_acc;
	logic                     shift_en;
	logic                     clear;
	logic                     push;
	logic                     push_ready;
	logic                     hit;
	pat_len_t                 len;
	logic [ADDRESS_WIDTH-1:0] count_nxt;
	logic [ADDRESS_WIDTH-1:0] offset;
	logic [NCELL-1:0][7:0]    din;
	logic [NCELL-1:0][7:0]    hist;
	logic [NCELL-1:0]         ok;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_length_q <= LEN_W'(1);
			pattern_q        <= '0;
			wildcard_q       <= '0;
			addr_origin_q    <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_PATTERN_LENGTH: pattern_length_q <= cfg.data[LEN_W-1:0];
				REG_PATTERN_LOW:    pattern_q[7:0]   <= cfg.data;
				REG_PATTERN_HIGH:   pattern_q[15:8]  <= cfg.data;
				REG_WILDCARD_MASK:  wildcard_q       <= cfg.data[PAT_BYTES-1:0];
				REG_ADDR_ORIGIN:    addr_origin_q    <= cfg.data[OUT_ADDR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign len = (pattern_length_q > NCELL_LEN) ? NCELL_LEN : pattern_length_q;

	assign in_acc   = byte_in.valid && byte_in.ready;
	assign shift_en = in_acc && !scan_done_q;
	// Every accepted last byte ends the scan, whatever else it does.
	assign clear    = in_acc && byte_in.last_byte;

	assign count_nxt = (count_q == '1) ? count_q : count_q + ADDRESS_WIDTH'(1);

	assign din[0] = byte_in.data_byte;
	for (genvar i = 1; i < NCELL; i++) begin : g_link
		assign din[i] = hist[i-1];
	end

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		wbps_cell #(
			.INDEX(i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (shift_en),
			.clear    (clear),
			.din      (din[i]),
			.pat_len  (len),
			.pat_bytes(pattern_q),
			.wild_mask(wildcard_q),
			.hist_q   (hist[i]),
			.ok       (ok[i])
		);
	end

	assign hit    = (count_nxt >= ADDRESS_WIDTH'(len)) && (&ok);
	assign offset = (len == '0) ? count_nxt - ADDRESS_WIDTH'(1)
	                            : count_nxt - ADDRESS_WIDTH'(len);
	assign push   = shift_en && (hit || byte_in.last_byte);

	// The input stalls whenever the first result stage is full and cannot move on.
	assign byte_in.ready = push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			scan_done_q <= 1'b0;
		end else if (clear) begin
			count_q     <= '0;
			scan_done_q <= 1'b0;
		end else if (shift_en) begin
			count_q <= count_nxt;
			if (hit) begin
				scan_done_q <= 1'b1;
			end
		end
	end

	wbps_result #(
		.ADDRESS_WIDTH(ADDRESS_WIDTH)
	) u_result (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.found       (hit),
		.offset      (offset),
		.addr_origin (addr_origin_q),
		.push_ready  (push_ready),
		.result_out  (result_out)
	);

endmodule

>>> dv/wildcard_byte_pattern_scan_core_tb.sv
`timescale 1ns / 100ps

module wildcard_byte_pattern_scan_core_tb;
	import wbps_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 1000000;
	localparam int unsigned ITEM_TARGET   = 1650;
	localparam int unsigned SETTLE_CYCLES = 6;

	typedef struct packed {
		logic      found;
		out_addr_t addr;
	} scan_result_t;

	typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		logic [7:0]            data_b;
		logic                  lst;
		logic                  typed;
		scan_result_t          res;
	} dir_row_t;

	// Register writes and bytes in order; a typed result is pushed instead of the predicted one.
	dir_row_t directed_rows [35] = '{
		'{ROW_BYTE, REG_PATTERN_LENGTH, 64'd0, 8'h00, 1'b0, 1'b1, '{1'b1, 48'h0}},
		'{ROW_BYTE, REG_PATTERN_LENGTH, 64'd0, 8'hFF, 1'b1, 1'b0, '{1'b0, 48'h0}},
		'{ROW_BYTE, REG_PATTERN_LENGTH, 64'd0, 8'hFF, 1'b1, 1'b1, '{1'b0, 48'h0}},
		'{ROW_CFG, REG_PATTERN_LENGTH, 64'd0, 8'h00, 1'b0, 1'b0, '{1'b0, 48'h0}},
		'{ROW_BYTE, REG_PATTERN_LENGTH, 64'd0, 8'hA5, 1'b1, 1'b1, '{1'b1, 48'h0}},
		'{ROW_CFG, REG_ADDR_ORIGIN, 64'h0000_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, '{1'b0, 48'h0}},
		'{ROW_CFG, REG_PATTERN_LOW, 64'h0000_0000_0033_2211, 8'h00, 1'b0, 1'b0, '{1'b0, 48'h0}},
		'{ROW_CFG, REG_PATTERN_LENGTH, 64'd3, 8'h00, 1'b0, 1'b0, '{1'b0, 48'h0}},
		'{ROW_BYTE, REG_PATTERN_LENGTH, 64'd0, 8'h99, 1'b0, 1'b0, '{1'b0, 48'h0}},
		'{ROW_BYTE, REG_PATTERN_LENGTH, 64'd0, 8'h11, 1'b0, 1'b0, '{1'b0, 48'h0}},
		'{ROW_BYTE, REG_PATTERN_LENGTH, 64'd0, 8'h22, 1'b0, 1'b0, '{1'b0, 48'h0}},
		'{ROW_BYTE, REG_PATTERN_LENGTH, 64'd0, 8'h33, 1'b1, 1'b1, '{1'b1, 48'h0}},
		'{ROW_CFG, REG_PATTERN_LOW, 64'd0, 8'h00, 1'b0, 1'b0, '{1'b0, 48'h0}},
		'{ROW_BYTE, REG_PATTERN_LENGTH, 64'd0, 8'h00, 1'b0, 1'b0, '{1'b0, 48'h0}},
		'{ROW_BYTE, REG_PATTERN_LENGTH, 64'd0, 8'h00, 1'b1, 1'b1, '{1'b0, 48'h0}},
		'{ROW_CFG, REG_PATTERN_HIGH, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, '{1'b0, 48'h0}},
		'{ROW_CFG, REG_WILDCARD_MASK, 64'h0000_0000_0000_00FF, 8'h00, 1'b0, 1'b0, '{1'b0, 48'h0}},
		'{ROW_CFG, REG_PATTERN_LENGTH, 64'd31, 8'h00, 1'b0, 1'b0, '{1'b0, 48'h0}},
		'{ROW_CFG, REG_ADDR_ORIGIN, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, '{1'b0, 48'h0}},
		'{ROW_BYTE, REG_PATTERN_LENGTH, 64'd0, 8'h00, 1'b0, 1'b0, '{1'b0, 48'h0}},
		'{ROW_BYTE, REG_PATTERN_LENGTH, 64'd0, 8'h80, 1'b0, 1'b0, '{1'b0, 48'h0}},
		'{ROW_BYTE, REG_PATTERN_LENGTH, 64'd0, 8'h7F, 1'b0, 1'b0, '{1'b0, 48'h0}},
		'{ROW_BYTE, REG_PATTERN_LENGTH, 64'd0, 8'h01, 1'b0, 1'b0, '{1'b0, 48'h0}},
		'{ROW_BYTE, REG_PATTERN_LENGTH, 64'd0, 8'hFE, 1'b0, 1'b0, '{1'b0, 48'h0}},
		'{ROW_BYTE, REG_PATTERN_LENGTH, 64'd0, 8'h55, 1'b0, 1'b0, '{1'b0, 48'h0}},
		'{ROW_BYTE, REG_PATTERN_LENGTH, 64'd0, 8'hAA, 1'b0, 1'b0, '{1'b0, 48'h0}},
		'{ROW_BYTE, REG_PATTERN_LENGTH, 64'd0, 8'hC3, 1'b0, 1'b0, '{1'b0, 48'h0}},
		'{ROW_BYTE, REG_PATTERN_LENGTH, 64'd0, 8'hFF, 1'b0, 1'b0, '{1'b0, 48'h0}},
		'{ROW_BYTE, REG_PATTERN_LENGTH, 64'd0, 8'hFF, 1'b0, 1'b0, '{1'b0, 48'h0}},
		'{ROW_BYTE, REG_PATTERN_LENGTH, 64'd0, 8'hFF, 1'b0, 1'b0, '{1'b0, 48'h0}},
		'{ROW_BYTE, REG_PATTERN_LENGTH, 64'd0, 8'hFF, 1'b0, 1'b0, '{1'b0, 48'h0}},
		'{ROW_BYTE, REG_PATTERN_LENGTH, 64'd0, 8'hFF, 1'b0, 1'b0, '{1'b0, 48'h0}},
		'{ROW_BYTE, REG_PATTERN_LENGTH, 64'd0, 8'hFF, 1'b0, 1'b0, '{1'b0, 48'h0}},
		'{ROW_BYTE, REG_PATTERN_LENGTH, 64'd0, 8'hFF, 1'b0, 1'b0, '{1'b0, 48'h0}},
		'{ROW_BYTE, REG_PATTERN_LENGTH, 64'd0, 8'hFF, 1'b1, 1'b1, '{1'b1, 48'hFFFF_FFFF_FFFF}}
	};

	logic clk = 1'b0;
	logic arst_n;

	wbps_byte_if   byte_ch ();
	wbps_result_if res_ch ();
	wbps_cfg_if    cfg_ch ();

	wildcard_byte_pattern_scan_core #(
		.PATTERN_MAX  (16),
		.ADDRESS_WIDTH(48)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_in   (byte_ch),
		.result_out(res_ch),
		.cfg       (cfg_ch)
	);

	always #4 clk = ~clk;

	// Shadow copy of the registers and of the scan state.
	pat_len_t              cfg_len;
	logic [63:0]           cfg_low;
	logic [63:0]           cfg_high;
	wild_mask_t            cfg_wild;
	out_addr_t             cfg_base;
	pat_bytes_t            recent;
	logic [OUT_ADDR_W-1:0] seen_count;
	bit                    scan_done;

	scan_result_t pending_results [$];
	int unsigned  errors = 0;
	int unsigned  items_counted = 0;
	int unsigned  cycle_count = 0;
	bit           tx_idle_on = 1'b1;
	bit           rx_idle_on = 1'b1;

	function automatic int unsigned draw_wait(input bit on);
		return on ? $urandom_range(0, 16) : 0;
	endfunction

	function automatic int unsigned active_len();
		return (cfg_len > PAT_BYTES) ? PAT_BYTES : cfg_len;
	endfunction

	function automatic void restart_scan();
		recent = '0;
		seen_count = '0;
		scan_done = 1'b0;
	endfunction

	function automatic bit predict_byte(input logic [7:0] data_b, input logic lst,
			output scan_result_t r);
		int unsigned n;
		bit hit;
		logic [127:0] pat;
		logic [OUT_ADDR_W-1:0] ofs;
		r = '0;
		if (scan_done) begin
			if (lst)
				restart_scan();
			return 1'b0;
		end
		recent = {recent[PAT_BYTES-2:0], data_b};
		if (seen_count != '1)
			seen_count++;
		n = active_len();
		pat = {cfg_high, cfg_low};
		// The oldest byte of the window lines up with pattern byte zero.
		hit = (seen_count >= n);
		for (int k = 0; k < n; k++) begin
			if (!cfg_wild[k] && recent[n-1-k] != pat[k*8 +: 8])
				hit = 1'b0;
		end
		if (hit) begin
			ofs = (n == 0) ? seen_count - OUT_ADDR_W'(1) : seen_count - OUT_ADDR_W'(n);
			r.found = 1'b1;
			r.addr = cfg_base + ofs;
			if (lst)
				restart_scan();
			else
				scan_done = 1'b1;
			return 1'b1;
		end
		if (lst) begin
			restart_scan();
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic wait_idle();
		byte_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Leaves valid high so that back-to-back writes need no gap; the caller lowers it.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		case (idx)
			REG_PATTERN_LENGTH: cfg_len = value[LEN_W-1:0];
			REG_PATTERN_LOW:    cfg_low = value;
			REG_PATTERN_HIGH:   cfg_high = value;
			REG_WILDCARD_MASK:  cfg_wild = value[PAT_BYTES-1:0];
			REG_ADDR_ORIGIN:    cfg_base = value[OUT_ADDR_W-1:0];
			default: ;
		endcase
	endtask

	task automatic send_byte(input logic [7:0] data_b, input logic lst, input bit typed,
			input scan_result_t typed_res);
		int unsigned gap;
		bit got;
		scan_result_t r;
		gap = draw_wait(tx_idle_on);
		if (gap != 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.data_byte <= data_b;
		byte_ch.last_byte <= lst;
		@(posedge clk);
		while (!byte_ch.ready)
			@(posedge clk);
		got = predict_byte(data_b, lst, r);
		if (typed)
			pending_results.push_back(typed_res);
		else if (got)
			pending_results.push_back(r);
		items_counted++;
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("wildcard_byte_pattern_scan_core_tb: FAIL");
			$finish;
		end
	end

	// Result side: random stalls, and every transaction is checked against the oldest expectation.
	initial begin
		int unsigned stall;
		scan_result_t want;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = draw_wait(rx_idle_on);
			if (stall != 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			@(posedge clk);
			while (!(res_ch.valid && res_ch.ready))
				@(posedge clk);
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual found=%0b address=%h",
					$time, res_ch.match_found, res_ch.match_address);
			end else begin
				want = pending_results.pop_front();
				if (res_ch.match_found !== want.found) begin
					errors++;
					$display("%0t: match_found expected %0b, actual %0b",
						$time, want.found, res_ch.match_found);
				end
				if (res_ch.match_address !== want.addr) begin
					errors++;
					$display("%0t: match_address expected %h, actual %h",
						$time, want.addr, res_ch.match_address);
				end
			end
		end
	end

	initial begin
		bit prev_cfg;
		bit small_set;
		bit cut;
		int unsigned nregions;
		int unsigned rlen;
		int unsigned start;
		int unsigned n;
		logic [63:0] w;
		logic [127:0] pat;
		logic [7:0] region [$];

		arst_n <= 1'b0;
		byte_ch.valid <= 1'b0;
		byte_ch.data_byte <= 8'h00;
		byte_ch.last_byte <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_PATTERN_LENGTH;
		cfg_ch.data <= '0;
		cfg_len = LEN_W'(1);
		cfg_low = '0;
		cfg_high = '0;
		cfg_wild = '0;
		cfg_base = '0;
		restart_scan();
		prev_cfg = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				if (!prev_cfg)
					wait_idle();
				write_reg(directed_rows[i].idx, directed_rows[i].data);
				prev_cfg = 1'b1;
			end else begin
				if (prev_cfg)
					cfg_ch.valid <= 1'b0;
				send_byte(directed_rows[i].data_b, directed_rows[i].lst,
					directed_rows[i].typed, directed_rows[i].res);
				prev_cfg = 1'b0;
			end
		end

		// Each phase waits for the pipeline to drain, reprograms every register and
		// streams a few regions; the last region is sometimes cut so the next
		// phase reprograms in the middle of a scan.
		while (items_counted < ITEM_TARGET) begin
			wait_idle();
			tx_idle_on = ($urandom_range(0, 3) != 0);
			rx_idle_on = ($urandom_range(0, 3) != 0);

			w = {$urandom, $urandom};
			case ($urandom_range(0, 7))
				0: w[LEN_W-1:0] = '0;
				1: w[LEN_W-1:0] = LEN_W'($urandom_range(17, 31));
				2: w[LEN_W-1:0] = LEN_W'(16);
				3: w[LEN_W-1:0] = LEN_W'($urandom_range(7, 15));
				default: w[LEN_W-1:0] = LEN_W'($urandom_range(1, 6));
			endcase
			write_reg(REG_PATTERN_LENGTH, w);

			small_set = 1'($urandom_range(0, 1));
			for (int h = 0; h < 2; h++) begin
				w = {$urandom, $urandom};
				case ($urandom_range(0, 7))
					0: w = '0;
					1: w = '1;
					default: ;
				endcase
				if (small_set)
					w &= 64'h0303_0303_0303_0303;
				write_reg((h == 0) ? REG_PATTERN_LOW : REG_PATTERN_HIGH, w);
			end

			w = {$urandom, $urandom};
			case ($urandom_range(0, 7))
				0: w[15:0] = '0;
				1: w[15:0] = '1;
				2, 3: ;
				default: w[15:0] = w[15:0] & w[31:16] & w[47:32];
			endcase
			write_reg(REG_WILDCARD_MASK, w);

			w = {$urandom, $urandom};
			case ($urandom_range(0, 5))
				0: w[47:0] = '0;
				1: w[47:0] = '1;
				2: w[47:0] = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 40));
				default: ;
			endcase
			write_reg(REG_ADDR_ORIGIN, w);
			cfg_ch.valid <= 1'b0;

			nregions = $urandom_range(1, 6);
			for (int g = 0; g < nregions; g++) begin
				rlen = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
				region.delete();
				for (int i = 0; i < rlen; i++)
					region.push_back(8'(small_set ? $urandom_range(0, 3) : $urandom_range(0, 255)));
				// Plant the pattern at a random spot; it may run past the end of the region.
				if ($urandom_range(0, 2) != 0) begin
					n = active_len();
					start = $urandom_range(0, rlen - 1);
					pat = {cfg_high, cfg_low};
					for (int k = 0; k < n; k++) begin
						if (start + k < rlen && !cfg_wild[k])
							region[start + k] = pat[k*8 +: 8];
					end
				end
				cut = (g == nregions - 1) && ($urandom_range(0, 5) == 0);
				for (int i = 0; i < rlen; i++)
					send_byte(region[i], (i == rlen - 1) && !cut, 1'b0, '0);
			end
		end

		byte_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		if (errors == 0)
			$display("wildcard_byte_pattern_scan_core_tb: PASS");
		else
			$display("wildcard_byte_pattern_scan_core_tb: FAIL");
		$finish;
	end

endmodule
